// ===== design/observer_state_feedback_controller_top_defines.svh =====
// Assertion macros shared by the controller RTL.
// Each macro expects clk and rst_n in scope of the module that uses it.
`ifndef OBSERVER_STATE_FEEDBACK_CONTROLLER_TOP_DEFINES_SVH
`define OBSERVER_STATE_FEEDBACK_CONTROLLER_TOP_DEFINES_SVH

// Property checked at every edge outside reset.
`define OSFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition in one cycle implies a result in the next cycle.
`define OSFC_ASSERT_NXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== design/osfc_pkg.sv =====
// Shared types, constants and coefficient table of the observer state feedback controller.
// Used by osfc_mul, osfc_duty and the top level; no dependencies.
package osfc_pkg;

  localparam int FRAC_BITS_DEF = 24;

  // Port widths
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 152;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int PWM_W      = 11;
  localparam int DRIVE_W    = 29;
  localparam int EST_W      = 48;
  localparam int TARGET_W   = 32;

  // Shared multiplier geometry
  localparam int OP_W      = 49;   // signed operand
  localparam int OP_MAG_W  = 48;
  localparam int COEF_W    = 54;
  localparam int HALF_OP   = 24;
  localparam int HALF_C    = 27;
  localparam int ACC_W     = OP_MAG_W + COEF_W;
  localparam int MAG_W     = 60;
  localparam int RES_W     = 61;
  localparam int COEF_FRAC = 40;
  localparam int SUM_W     = 62;

  localparam logic [MAG_W-1:0] PROD_LIM = 60'd1 << 59;

  localparam logic signed [SUM_W-1:0] EST_MAX = SUM_W'((64'd1 << 47) - 64'd1);
  localparam logic signed [SUM_W-1:0] EST_MIN = ~EST_MAX;

  // Duty scaling
  localparam logic [PWM_W-1:0] DUTY_LIMIT = 11'd2040;
  localparam logic [15:0]      DIV3_RECIP = 16'd43691;

  // Configuration register index (paddr bit 2)
  localparam logic CFG_IDX_TARGET = 1'b0;
  localparam logic CFG_IDX_MODE   = 1'b1;
  localparam logic [TARGET_W-1:0] TARGET_RST = 32'd26353589;

  // Sequencer steps, one coefficient product each
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_Y    = 4'd0;
  localparam logic [STEP_W-1:0] STEP_A_E  = 4'd1;
  localparam logic [STEP_W-1:0] STEP_A_U  = 4'd2;
  localparam logic [STEP_W-1:0] STEP_A_W  = 4'd3;
  localparam logic [STEP_W-1:0] STEP_W_E  = 4'd4;
  localparam logic [STEP_W-1:0] STEP_W_U  = 4'd5;
  localparam logic [STEP_W-1:0] STEP_W_W  = 4'd6;
  localparam logic [STEP_W-1:0] STEP_INT  = 4'd7;
  localparam logic [STEP_W-1:0] STEP_V_A  = 4'd8;
  localparam logic [STEP_W-1:0] STEP_V_W  = 4'd9;
  localparam logic [STEP_W-1:0] STEP_V_I  = 4'd10;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_V_I;

  // Coefficient magnitudes, Q.40 rounded to nearest
  localparam logic [63:0] C_K_ANG   = ((64'd6376 << 40) + 64'd5) / 64'd10;
  localparam logic [63:0] C_K_RATE  = ((64'd2733 << 40) + 64'd50) / 64'd100;
  localparam logic [63:0] C_K_INT   = (64'd5477 << 40);
  localparam logic [63:0] C_LK_ANG  = ((64'd1001 << 40) + 64'd500) / 64'd1000;
  localparam logic [63:0] C_LK_RATE = ((64'd7751 << 40) + 64'd5000) / 64'd10000;
  localparam logic [63:0] C_KF_AU   = ((64'd1953 << 40) + 64'd50000000) / 64'd100000000;
  localparam logic [63:0] C_KF_AW   = ((64'd987 << 40) + 64'd500000) / 64'd1000000;
  localparam logic [63:0] C_KF_WU   = ((64'd389 << 40) + 64'd5000) / 64'd10000;
  localparam logic [63:0] C_KF_WW   = ((64'd9747 << 40) + 64'd5000) / 64'd10000;
  localparam logic [63:0] C_PE_ANG  = ((64'd1774 << 40) + 64'd500) / 64'd1000;
  localparam logic [63:0] C_PE_DT   = ((64'd1 << 40) + 64'd500) / 64'd1000;
  localparam logic [63:0] C_PE_RATE = ((64'd4046 << 40) + 64'd5) / 64'd10;
  localparam logic [63:0] C_PE_WU   = ((64'd394 << 40) + 64'd5000) / 64'd10000;
  localparam logic [63:0] C_PE_WW   = ((64'd256 << 40) + 64'd5000) / 64'd10000;
  // Count to angle factor pi/1200, Q.60
  localparam logic [63:0] PI_Q60    = 64'h3243F6A8885A308D;
  localparam logic [63:0] C_RES     = (PI_Q60 + 64'd600) / 64'd1200;

  typedef struct packed {
    logic              neg;
    logic [COEF_W-1:0] mag;
  } coef_t;

  typedef struct packed {
    logic            start;
    logic [OP_W-1:0] op;     // two's complement
    coef_t           coef;
    logic            ysh;    // count to angle scaling instead of Q.40
  } mul_req_t;

  typedef struct packed {
    logic             done;
    logic [RES_W-1:0] res;   // two's complement
  } mul_rsp_t;

  function automatic coef_t mk_coef(logic neg, logic [63:0] c);
    coef_t r;
    r.neg = neg;
    r.mag = c[COEF_W-1:0];
    return r;
  endfunction

  // Mode 1 is the steady Kalman observer, mode 0 the Euler pole placement one.
  function automatic coef_t coef_of(logic [STEP_W-1:0] step, logic mode);
    coef_t r;
    unique case (step)
      STEP_Y:   r = mk_coef(1'b0, C_RES);
      STEP_A_E: r = mode ? mk_coef(1'b1, C_LK_ANG) : mk_coef(1'b1, C_PE_ANG);
      STEP_A_U: r = mode ? mk_coef(1'b0, C_KF_AU) : mk_coef(1'b0, 64'd0);
      STEP_A_W: r = mode ? mk_coef(1'b0, C_KF_AW) : mk_coef(1'b0, C_PE_DT);
      STEP_W_E: r = mode ? mk_coef(1'b1, C_LK_RATE) : mk_coef(1'b1, C_PE_RATE);
      STEP_W_U: r = mode ? mk_coef(1'b0, C_KF_WU) : mk_coef(1'b0, C_PE_WU);
      STEP_W_W: r = mode ? mk_coef(1'b0, C_KF_WW) : mk_coef(1'b1, C_PE_WW);
      STEP_INT: r = mk_coef(1'b0, C_PE_DT);
      STEP_V_A: r = mk_coef(1'b1, C_K_ANG);
      STEP_V_W: r = mk_coef(1'b1, C_K_RATE);
      STEP_V_I: r = mk_coef(1'b0, C_K_INT);
      default:  r = mk_coef(1'b0, 64'd0);
    endcase
    return r;
  endfunction

endpackage

// ===== design/observer_state_feedback_controller_top.sv =====
// Top level of the observer state feedback controller: stream ports, APB registers,
// control sequencer and state. Depends on osfc_pkg, osfc_mul and osfc_duty.
//
// One item per control tick. An item with run high needs eleven coefficient products, made
// one after another on the single shared multiplier, each from an operand load, four
// 24x27 partial products, a round and saturate step and a sequencing step. After them
// come the duty conversion, the loading of the result and the idle state, the only one in
// which the next item is taken. An item with run low reports the held state through the
// result load and then returns to idle.
// The result sits in an output register, so an item is accepted while the previous result
// waits to be taken; the sequencer only stalls when a new result finds that register
// still full.
`include "observer_state_feedback_controller_top_defines.svh"

module observer_state_feedback_controller_top #(
  parameter int FRAC_BITS = osfc_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [osfc_pkg::IN_DATA_W-1:0]    in_tdata,   // [23:0] encoder_count
  input  logic                              in_tuser,   // [0] run
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [10:0] pwm_a, [21:11] pwm_b, [50:22] drive_voltage, [98:51] est_angle,
  // [146:99] est_rate, [151:147] zero
  output logic [osfc_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [osfc_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [osfc_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [osfc_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);
  import osfc_pkg::*;

  localparam int V_W = FRAC_BITS + 5;
  localparam logic [SUM_W-1:0] VLIM_U = SUM_W'(64'd12 << FRAC_BITS);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DUTY = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [STEP_W-1:0]       step_r, step_nxt;
  logic                    go_r, go_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [TARGET_W-1:0]     target_r;
  logic                    mode_r;
  logic signed [EST_W-1:0] angle_r, angle_nxt;
  logic signed [EST_W-1:0] rate_r, rate_nxt;
  logic signed [V_W-1:0]   integ_r, integ_nxt;
  logic signed [V_W-1:0]   volt_r, volt_nxt;
  logic [PWM_W-1:0]        pwm_a_r, pwm_a_nxt;
  logic [PWM_W-1:0]        pwm_b_r, pwm_b_nxt;
  logic [IN_DATA_W-1:0]    count_r, count_nxt;
  logic signed [OP_W-1:0]  e_r, e_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [OUT_DATA_W-1:0]   out_data_r, out_data_nxt;

  mul_req_t                mreq;
  mul_rsp_t                mrsp;
  logic signed [OP_W-1:0]  opnd;
  logic signed [SUM_W-1:0] res_s;
  logic signed [SUM_W-1:0] total;
  logic signed [SUM_W-1:0] y_diff;
  logic signed [SUM_W-1:0] vlim_s;
  logic signed [SUM_W-1:0] v_full;
  logic signed [EST_W-1:0] est_sat;
  logic signed [V_W-1:0]   v_sat;
  logic signed [63:0]      volt64;
  logic [PWM_W-1:0]        duty_a;
  logic [PWM_W-1:0]        duty_b;
  logic                    cfg_wr;
  logic                    in_acc;

  // ---------------------------------------------------------------- config port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= TARGET_RST;
      mode_r   <= 1'b1;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        CFG_IDX_TARGET: target_r <= cfg_pwdata[TARGET_W-1:0];
        CFG_IDX_MODE:   mode_r   <= cfg_pwdata[0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      CFG_IDX_TARGET: cfg_prdata = target_r;
      CFG_IDX_MODE:   cfg_prdata = {{(CFG_DATA_W-1){1'b0}}, mode_r};
      default:        cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- datapath
  always_comb begin
    case (step_r) inside
      STEP_Y:                     opnd = OP_W'($signed(count_r));
      STEP_A_E, STEP_W_E:         opnd = e_r;
      STEP_A_U, STEP_W_U:         opnd = OP_W'(volt_r);
      STEP_A_W, STEP_W_W, STEP_V_W: opnd = OP_W'(rate_r);
      STEP_INT:                   opnd = OP_W'($signed(target_r)) - OP_W'(angle_r);
      STEP_V_A:                   opnd = OP_W'(angle_r);
      default:                    opnd = OP_W'(integ_r);
    endcase
  end

  assign mreq.start = go_r;
  assign mreq.op    = opnd;
  assign mreq.coef  = coef_of(step_r, mode_r);
  assign mreq.ysh   = (step_r == STEP_Y);

  osfc_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  osfc_duty #(.FRAC_BITS(FRAC_BITS)) u_duty (
    .voltage (volt_r),
    .pwm_a   (duty_a),
    .pwm_b   (duty_b)
  );

  assign res_s  = SUM_W'($signed(mrsp.res));
  assign total  = sum_r + res_s;
  assign y_diff = SUM_W'(angle_r) - res_s;
  assign vlim_s = $signed(VLIM_U);

  always_comb begin
    if (total > EST_MAX) begin
      est_sat = EST_MAX[EST_W-1:0];
    end else if (total < EST_MIN) begin
      est_sat = EST_MIN[EST_W-1:0];
    end else begin
      est_sat = total[EST_W-1:0];
    end
    if (total > vlim_s) begin
      v_full = vlim_s;
    end else if (total < -vlim_s) begin
      v_full = -vlim_s;
    end else begin
      v_full = total;
    end
    v_sat = v_full[V_W-1:0];
  end

  assign volt64 = 64'(volt_r);

  // ---------------------------------------------------------------- sequencer
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    go_nxt        = 1'b0;
    out_valid_nxt = out_valid_r;
    angle_nxt     = angle_r;
    rate_nxt      = rate_r;
    integ_nxt     = integ_r;
    volt_nxt      = volt_r;
    pwm_a_nxt     = pwm_a_r;
    pwm_b_nxt     = pwm_b_r;
    count_nxt     = count_r;
    e_nxt         = e_r;
    sum_nxt       = sum_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          count_nxt = in_tdata;
          if (in_tuser) begin
            step_nxt  = STEP_Y;
            go_nxt    = 1'b1;
            state_nxt = S_MUL;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_MUL: begin
        if (mrsp.done) begin
          // fold the product in and seed the next sum where a group ends
          case (step_r)
            STEP_Y: begin
              e_nxt   = y_diff[OP_W-1:0];
              sum_nxt = SUM_W'(angle_r);
            end
            STEP_A_W: begin
              angle_nxt = est_sat;
              sum_nxt   = mode_r ? '0 : SUM_W'(rate_r);
            end
            STEP_W_W: begin
              rate_nxt = est_sat;
              sum_nxt  = SUM_W'(integ_r);
            end
            STEP_INT: begin
              integ_nxt = v_sat;
              sum_nxt   = '0;
            end
            STEP_V_I: volt_nxt = v_sat;
            default:  sum_nxt = total;
          endcase
          if (step_r == STEP_LAST) begin
            state_nxt = S_DUTY;
          end else begin
            step_nxt = step_r + STEP_W'(1);
            go_nxt   = 1'b1;
          end
        end
      end
      S_DUTY: begin
        pwm_a_nxt = duty_a;
        pwm_b_nxt = duty_b;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_data_nxt = {{(OUT_DATA_W - 2*PWM_W - DRIVE_W - 2*EST_W){1'b0}},
                          rate_r, angle_r, volt64[DRIVE_W-1:0], pwm_b_r, pwm_a_r};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= STEP_Y;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
      angle_r     <= '0;
      rate_r      <= '0;
      integ_r     <= '0;
      volt_r      <= '0;
      pwm_a_r     <= '0;
      pwm_b_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      go_r        <= go_nxt;
      out_valid_r <= out_valid_nxt;
      angle_r     <= angle_nxt;
      rate_r      <= rate_nxt;
      integ_r     <= integ_nxt;
      volt_r      <= volt_nxt;
      pwm_a_r     <= pwm_a_nxt;
      pwm_b_r     <= pwm_b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    count_r    <= count_nxt;
    e_r        <= e_nxt;
    sum_r      <= sum_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `OSFC_ASSERT(a_done_in_mul, mrsp.done |-> (state_r == S_MUL), "product returned outside a tick")
  `OSFC_ASSERT(a_step_range, (state_r == S_MUL) |-> (step_r <= STEP_LAST), "step beyond program")
  `OSFC_ASSERT_NXT(a_hold_tick, in_acc && !in_tuser, state_r == S_OUT, "hold item started work")

endmodule

// ===== design/osfc_mul.sv =====
// Shared fixed-point multiplier: rounded, saturated product of a signed operand and a
// signed coefficient, built from four 24x27 partial products. Depends on osfc_pkg.
`include "observer_state_feedback_controller_top_defines.svh"

module osfc_mul #(
  parameter int FRAC_BITS = osfc_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  osfc_pkg::mul_req_t req,
  output osfc_pkg::mul_rsp_t rsp
);
  import osfc_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE = 3'b001,
    M_MUL  = 3'b010,
    M_FIN  = 3'b100
  } mstate_t;

  localparam int Y_SH = 60 - FRAC_BITS;
  localparam logic [ACC_W-1:0] RND_C = ACC_W'(1) << (COEF_FRAC - 1);
  localparam logic [ACC_W-1:0] RND_Y = ACC_W'(1) << (Y_SH - 1);
  localparam logic signed [RES_W-1:0] RES_MAX = RES_W'(PROD_LIM);

  mstate_t               state_r, state_nxt;
  logic [1:0]            cnt_r, cnt_nxt;
  logic [OP_MAG_W-1:0]   opmag_r, opmag_nxt;
  logic [COEF_W-1:0]     cmag_r, cmag_nxt;
  logic                  neg_r, neg_nxt;
  logic                  ysh_r, ysh_nxt;
  logic [ACC_W-1:0]      acc_r, acc_nxt;
  logic [RES_W-1:0]      res_r, res_nxt;
  logic                  done_r, done_nxt;

  logic [OP_W-1:0]              op_abs;
  logic [HALF_OP-1:0]           op_h;
  logic [HALF_C-1:0]            c_h;
  logic [HALF_OP+HALF_C-1:0]    pp;
  logic [ACC_W-1:0]             pp_sh;
  logic [ACC_W-1:0]             shifted;
  logic [MAG_W-1:0]             mag;

  assign op_abs = req.op[OP_W-1] ? (~req.op + OP_W'(1)) : req.op;
  assign op_h   = cnt_r[0] ? opmag_r[OP_MAG_W-1:HALF_OP] : opmag_r[HALF_OP-1:0];
  assign c_h    = cnt_r[1] ? cmag_r[COEF_W-1:HALF_C] : cmag_r[HALF_C-1:0];
  assign pp     = (HALF_OP+HALF_C)'(op_h) * (HALF_OP+HALF_C)'(c_h);

  always_comb begin
    case (cnt_r)
      2'd0:    pp_sh = ACC_W'(pp);
      2'd1:    pp_sh = ACC_W'(pp) << HALF_OP;
      2'd2:    pp_sh = ACC_W'(pp) << HALF_C;
      default: pp_sh = ACC_W'(pp) << (HALF_OP + HALF_C);
    endcase
  end

  assign shifted = ysh_r ? (acc_r >> Y_SH) : (acc_r >> COEF_FRAC);
  assign mag     = (shifted > ACC_W'(PROD_LIM)) ? PROD_LIM : shifted[MAG_W-1:0];

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    opmag_nxt = opmag_r;
    cmag_nxt  = cmag_r;
    neg_nxt   = neg_r;
    ysh_nxt   = ysh_r;
    acc_nxt   = acc_r;
    res_nxt   = res_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      M_IDLE: begin
        if (req.start) begin
          opmag_nxt = op_abs[OP_MAG_W-1:0];
          cmag_nxt  = req.coef.mag;
          neg_nxt   = req.op[OP_W-1] ^ req.coef.neg;
          ysh_nxt   = req.ysh;
          // preload the half-LSB so the final shift rounds half away from zero
          acc_nxt   = req.ysh ? RND_Y : RND_C;
          cnt_nxt   = 2'd0;
          state_nxt = M_MUL;
        end
      end
      M_MUL: begin
        acc_nxt = acc_r + pp_sh;
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          state_nxt = M_FIN;
        end
      end
      M_FIN: begin
        res_nxt   = neg_r ? (RES_W'(0) - {1'b0, mag}) : {1'b0, mag};
        done_nxt  = 1'b1;
        state_nxt = M_IDLE;
      end
      default: state_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    opmag_r <= opmag_nxt;
    cmag_r  <= cmag_nxt;
    neg_r   <= neg_nxt;
    ysh_r   <= ysh_nxt;
    acc_r   <= acc_nxt;
    res_r   <= res_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

  `OSFC_ASSERT(a_mul_start_idle, req.start |-> (state_r == M_IDLE), "multiplier started while busy")
  `OSFC_ASSERT(a_mul_latency, (req.start && state_r == M_IDLE) |-> ##6 done_r, "product late")
  `OSFC_ASSERT(a_mul_bound, done_r |-> ($signed(res_r) <= RES_MAX && $signed(res_r) >= -RES_MAX), "product beyond saturation limit")

endmodule

// ===== design/osfc_duty.sv =====
// Drive voltage to PWM duty: trunc(|u| * 2047 / 12), limited, split by sign onto two channels.
// Depends on osfc_pkg.
module osfc_duty #(
  parameter int FRAC_BITS = osfc_pkg::FRAC_BITS_DEF
) (
  input  logic signed [FRAC_BITS+4:0]      voltage,
  output logic [osfc_pkg::PWM_W-1:0]       pwm_a,
  output logic [osfc_pkg::PWM_W-1:0]       pwm_b
);
  import osfc_pkg::*;

  localparam int V_W = FRAC_BITS + 5;
  localparam int M_W = V_W + 11;

  logic [V_W-1:0]   mag;
  logic [M_W-1:0]   scaled;
  logic [12:0]      quarter;
  logic [28:0]      prod;
  logic [11:0]      quo;
  logic [PWM_W-1:0] duty;
  logic             pos;

  assign mag    = voltage[V_W-1] ? (~voltage + V_W'(1)) : voltage;
  assign scaled = (M_W'(mag) << 11) - M_W'(mag);
  // divide by 12 as a shift by FRAC_BITS+2 then an exact divide by 3
  assign quarter = scaled[FRAC_BITS+14:FRAC_BITS+2];
  assign prod    = 29'(quarter) * 29'(DIV3_RECIP);
  assign quo     = prod[28:17];
  assign duty    = (quo > 12'(DUTY_LIMIT)) ? DUTY_LIMIT : quo[PWM_W-1:0];
  assign pos     = !voltage[V_W-1] && (voltage != '0) && (duty != '0);
  assign pwm_a   = pos ? '0 : duty;
  assign pwm_b   = pos ? duty : '0;

endmodule
